>>> hw/rtl/cxe_pkg.sv
`default_nettype none

package cxe_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int ACC_W     = 48;
    localparam int STANDS_W  = 5;
    localparam int CHANS_W   = 7;
    localparam int LOG2_W    = 5;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int FRAME_W   = 17;
    localparam int RD_BL_W   = 8;
    localparam int RD_CH_W   = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_STANDS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_LOG2     = 2'd2;

    // register reset values and limits
    localparam logic [STANDS_W-1:0] STANDS_RESET   = 5'd16;
    localparam logic [CHANS_W-1:0]  CHANNELS_RESET = 7'd64;
    localparam logic [LOG2_W-1:0]   LOG2_LIMIT     = 5'd16;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample_re;
        logic signed [SAMPLE_W-1:0] sample_im;
        logic [RD_BL_W-1:0]         read_baseline;
        logic [RD_CH_W-1:0]         read_channel;
    } req_t;

    typedef struct packed {
        logic                    integration_done;
        logic signed [ACC_W-1:0] vis_re;
        logic signed [ACC_W-1:0] vis_im;
    } rsp_t;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic stand_wr;
        logic issue;
        logic overwrite;
        logic acc_rd;
    } mac_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/cxe_mac.sv
`default_nettype none

module cxe_mac #(
    parameter int MAX_STANDS   = 16,
    parameter int MAX_CHANNELS = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire cxe_pkg::mac_ctrl_t                   ctrl,
    input  wire logic [$clog2(MAX_STANDS)-1:0]        wr_idx,
    input  wire logic signed [cxe_pkg::SAMPLE_W-1:0]  sample_re,
    input  wire logic signed [cxe_pkg::SAMPLE_W-1:0]  sample_im,
    input  wire logic [$clog2(MAX_STANDS)-1:0]        s1,
    input  wire logic [$clog2(MAX_STANDS)-1:0]        s2,
    input  wire logic [$clog2(MAX_STANDS*(MAX_STANDS+1)/2*MAX_CHANNELS)-1:0] addr,
    output logic signed [cxe_pkg::ACC_W-1:0]          acc_re,
    output logic signed [cxe_pkg::ACC_W-1:0]          acc_im,
    output logic                                      busy
);

    localparam int NBL    = MAX_STANDS * (MAX_STANDS + 1) / 2;
    localparam int DEPTH  = NBL * MAX_CHANNELS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SW     = cxe_pkg::SAMPLE_W;
    localparam int PW     = cxe_pkg::PROD_W;
    localparam int UW     = cxe_pkg::SUM_W;
    localparam int AW     = cxe_pkg::ACC_W;

    // saturate a one-bit-wider sum to the accumulator range
    function automatic logic signed [AW-1:0] sat_acc(input logic signed [AW:0] v);
        logic signed [AW-1:0] r;
        begin
            if (v[AW] != v[AW-1])
            begin
                r = v[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
            end
            else
            begin
                r = v[AW-1:0];
            end
            return r;
        end
    endfunction

    logic [2*SW-1:0] stand_mem [MAX_STANDS];
    logic [2*AW-1:0] acc_mem [DEPTH];

    logic [2*SW-1:0]        sa_reg, sb_reg;
    logic                   v1_reg, v2_reg, v3_reg;
    logic                   ov1_reg, ov2_reg, ov3_reg;
    logic [ADDR_W-1:0]      addr1_reg, addr2_reg, addr3_reg;
    logic signed [PW-1:0]   p_ac_reg, p_bd_reg, p_bc_reg, p_ad_reg;
    logic signed [UW-1:0]   pr_reg, pi_reg;
    logic [2*AW-1:0]        acc_rd_reg;

    logic signed [SW-1:0]   a, b, c, d;
    logic [ADDR_W-1:0]      rd_addr;
    logic signed [AW-1:0]   old_re, old_im;
    logic signed [AW:0]     sum_re, sum_im;
    logic signed [AW-1:0]   new_re, new_im;

    // stand buffer, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (ctrl.stand_wr)
        begin
            stand_mem[wr_idx] <= {sample_re, sample_im};
        end
        sa_reg <= stand_mem[s1];
        sb_reg <= stand_mem[s2];
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign a = sa_reg[2*SW-1:SW];
    assign b = sa_reg[SW-1:0];
    assign c = sb_reg[2*SW-1:SW];
    assign d = sb_reg[SW-1:0];

    // products, then complex sums for x[s1] * conj(x[s2])
    always_ff @(posedge clk)
    begin
        ov1_reg   <= ctrl.overwrite;
        addr1_reg <= addr;
        ov2_reg   <= ov1_reg;
        addr2_reg <= addr1_reg;
        p_ac_reg  <= PW'(a) * PW'(c);
        p_bd_reg  <= PW'(b) * PW'(d);
        p_bc_reg  <= PW'(b) * PW'(c);
        p_ad_reg  <= PW'(a) * PW'(d);
        ov3_reg   <= ov2_reg;
        addr3_reg <= addr2_reg;
        pr_reg    <= UW'(p_ac_reg) + UW'(p_bd_reg);
        pi_reg    <= UW'(p_bc_reg) - UW'(p_ad_reg);
    end

    // accumulator read port serves the pipeline and read commands
    assign rd_addr = ctrl.acc_rd ? addr : addr2_reg;

    assign old_re = acc_rd_reg[2*AW-1:AW];
    assign old_im = acc_rd_reg[AW-1:0];
    assign sum_re = (AW+1)'(old_re) + (AW+1)'(pr_reg);
    assign sum_im = (AW+1)'(old_im) + (AW+1)'(pi_reg);
    assign new_re = ov3_reg ? AW'(pr_reg) : sat_acc(sum_re);
    assign new_im = ov3_reg ? AW'(pi_reg) : sat_acc(sum_im);

    // accumulator memory, read-modify-write
    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            acc_mem[addr3_reg] <= {new_re, new_im};
        end
        acc_rd_reg <= acc_mem[rd_addr];
    end

    assign acc_re = old_re;
    assign acc_im = old_im;
    assign busy   = v1_reg | v2_reg | v3_reg;

endmodule

`default_nettype wire

>>> hw/rtl/correlator_x_engine_baselines.sv
// push of a non-final stand: result in the cycle after the transfer, next item may follow
// push of the final stand: walks N(N+1)/2 baselines on one complex MAC, one per cycle,
//   result once the walk ends and the MAC pipeline drains; no new request is taken meanwhile
// read: the accumulator memory read is registered, then scaled into the result register
// reset clears counters, configuration registers and handshake state; the stand buffer and the
//   accumulators are not cleared and are overwritten by the first frame of an integration
`default_nettype none

module correlator_x_engine_baselines #(
    parameter int MAX_STANDS   = 16,
    parameter int MAX_CHANNELS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [cxe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cxe_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              req_valid,
    output logic                                   req_ready,
    input  wire cxe_pkg::req_t                     req,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output cxe_pkg::rsp_t                          rsp
);

    localparam int NBL      = MAX_STANDS * (MAX_STANDS + 1) / 2;
    localparam int ADDR_W   = $clog2(NBL * MAX_CHANNELS);
    localparam int SI_W     = $clog2(MAX_STANDS);
    localparam int STAND_CW = $clog2(MAX_STANDS + 1);
    localparam int CI_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CH_CW    = $clog2(MAX_CHANNELS + 1);
    localparam int NP_W     = 2 * STAND_CW;
    localparam int FW       = cxe_pkg::FRAME_W;
    localparam int AW       = cxe_pkg::ACC_W;

    cxe_pkg::state_t state_reg, state_next;

    logic [cxe_pkg::STANDS_W-1:0] active_stands_reg;
    logic [cxe_pkg::CHANS_W-1:0]  active_channels_reg;
    logic [cxe_pkg::LOG2_W-1:0]   frames_log2_reg;

    logic [SI_W-1:0]   stand_cnt_reg, stand_cnt_next;
    logic [CI_W-1:0]   chan_cnt_reg, chan_cnt_next;
    logic [FW-1:0]     frame_cnt_reg, frame_cnt_next;
    logic [SI_W-1:0]   s1_reg, s1_next, s2_reg, s2_next;
    logic [ADDR_W-1:0] walk_addr_reg, walk_addr_next;
    logic              ov_reg, ov_next;
    logic              done_reg, done_next;
    logic              rsp_valid_reg, rsp_valid_next;
    cxe_pkg::rsp_t     rsp_reg, rsp_next;

    logic [STAND_CW-1:0]        n_eff;
    logic [CH_CW-1:0]           nch_eff;
    logic [cxe_pkg::LOG2_W-1:0] lg_eff;
    logic [NP_W-1:0]            nbl_x2;
    logic                       accept;
    logic                       rd_ok;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       last_stand;
    logic                       s2_more, s1_more;
    logic [FW-1:0]              frame_inc, frame_thr;
    logic                       busy;
    cxe_pkg::mac_ctrl_t         ctrl;
    logic [ADDR_W-1:0]          mac_addr;
    logic signed [AW-1:0]       acc_re, acc_im;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_stands_reg   <= cxe_pkg::STANDS_RESET;
            active_channels_reg <= cxe_pkg::CHANNELS_RESET;
            frames_log2_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cxe_pkg::REG_ACTIVE_STANDS:
                    active_stands_reg <= cfg_data[cxe_pkg::STANDS_W-1:0];
                cxe_pkg::REG_ACTIVE_CHANNELS:
                    active_channels_reg <= cfg_data[cxe_pkg::CHANS_W-1:0];
                cxe_pkg::REG_FRAMES_LOG2:
                    frames_log2_reg <= cfg_data[cxe_pkg::LOG2_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // clamped settings
    always_comb
    begin
        if (active_stands_reg == '0)
            n_eff = STAND_CW'(1);
        else if (32'(active_stands_reg) > MAX_STANDS)
            n_eff = STAND_CW'(MAX_STANDS);
        else
            n_eff = STAND_CW'(active_stands_reg);

        if (active_channels_reg == '0)
            nch_eff = CH_CW'(1);
        else if (32'(active_channels_reg) > MAX_CHANNELS)
            nch_eff = CH_CW'(MAX_CHANNELS);
        else
            nch_eff = CH_CW'(active_channels_reg);

        lg_eff = (frames_log2_reg > cxe_pkg::LOG2_LIMIT) ? cxe_pkg::LOG2_LIMIT
                                                          : frames_log2_reg;
    end

    // read range check and address
    assign nbl_x2  = NP_W'(n_eff) * (NP_W'(n_eff) + NP_W'(1));
    assign rd_ok   = (32'(req.read_baseline) < 32'(nbl_x2 >> 1))
                   && (32'(req.read_channel) < 32'(nch_eff));
    assign rd_addr = ADDR_W'(32'(req.read_baseline) * MAX_CHANNELS
                             + 32'(req.read_channel));

    assign accept     = req_valid & req_ready;
    assign last_stand = !((STAND_CW'(stand_cnt_reg) + STAND_CW'(1)) < n_eff);
    assign s2_more    = (STAND_CW'(s2_reg) + STAND_CW'(1)) < n_eff;
    assign s1_more    = (STAND_CW'(s1_reg) + STAND_CW'(1)) < n_eff;
    assign frame_inc  = frame_cnt_reg + FW'(1);
    assign frame_thr  = FW'(1) << lg_eff;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cxe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == cxe_pkg::CMD_READ)
                    begin
                        if (rd_ok)
                            state_next = cxe_pkg::ST_READ;
                    end
                    else if (last_stand)
                    begin
                        state_next = cxe_pkg::ST_WALK;
                    end
                end
            end
            cxe_pkg::ST_WALK:
            begin
                if (!s2_more && !s1_more)
                    state_next = cxe_pkg::ST_DRAIN;
            end
            cxe_pkg::ST_DRAIN:
            begin
                if (!busy)
                    state_next = cxe_pkg::ST_IDLE;
            end
            cxe_pkg::ST_READ:
            begin
                state_next = cxe_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cxe_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake and unit control
    always_comb
    begin
        req_ready      = 1'b0;
        ctrl           = '0;
        mac_addr       = rd_addr;
        case (state_reg)
            cxe_pkg::ST_IDLE:
            begin
                req_ready     = !rsp_valid_reg || rsp_ready;
                ctrl.stand_wr = accept && (req.cmd == cxe_pkg::CMD_PUSH);
                ctrl.acc_rd   = accept && (req.cmd == cxe_pkg::CMD_READ) && rd_ok;
            end
            cxe_pkg::ST_WALK:
            begin
                ctrl.issue     = 1'b1;
                ctrl.overwrite = ov_reg;
                mac_addr       = walk_addr_reg;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // counters, walk indexes and result register
    always_comb
    begin
        stand_cnt_next = stand_cnt_reg;
        chan_cnt_next  = chan_cnt_reg;
        frame_cnt_next = frame_cnt_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        walk_addr_next = walk_addr_reg;
        ov_next        = ov_reg;
        done_next      = done_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        case (state_reg)
            cxe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == cxe_pkg::CMD_READ)
                    begin
                        // out-of-range read answers zero at once
                        if (!rd_ok)
                        begin
                            rsp_next       = '0;
                            rsp_valid_next = 1'b1;
                        end
                    end
                    else if (!last_stand)
                    begin
                        stand_cnt_next = stand_cnt_reg + SI_W'(1);
                        rsp_next       = '0;
                        rsp_valid_next = 1'b1;
                    end
                    else
                    begin
                        // channel complete: start the baseline walk
                        stand_cnt_next = '0;
                        s1_next        = '0;
                        s2_next        = '0;
                        walk_addr_next = ADDR_W'(chan_cnt_reg);
                        ov_next        = (frame_cnt_reg == '0);
                        done_next      = 1'b0;
                        if ((CH_CW'(chan_cnt_reg) + CH_CW'(1)) < nch_eff)
                        begin
                            chan_cnt_next = chan_cnt_reg + CI_W'(1);
                        end
                        else
                        begin
                            chan_cnt_next = '0;
                            if (frame_inc >= frame_thr)
                            begin
                                frame_cnt_next = '0;
                                done_next      = 1'b1;
                            end
                            else
                            begin
                                frame_cnt_next = frame_inc;
                            end
                        end
                    end
                end
            end
            cxe_pkg::ST_WALK:
            begin
                walk_addr_next = walk_addr_reg + ADDR_W'(MAX_CHANNELS);
                if (s2_more)
                begin
                    s2_next = s2_reg + SI_W'(1);
                end
                else if (s1_more)
                begin
                    s1_next = s1_reg + SI_W'(1);
                    s2_next = s1_reg + SI_W'(1);
                end
            end
            cxe_pkg::ST_DRAIN:
            begin
                if (!busy)
                begin
                    rsp_next                  = '0;
                    rsp_next.integration_done = done_reg;
                    rsp_valid_next            = 1'b1;
                end
            end
            cxe_pkg::ST_READ:
            begin
                rsp_next.integration_done = 1'b0;
                rsp_next.vis_re           = acc_re >>> lg_eff;
                rsp_next.vis_im           = acc_im >>> lg_eff;
                rsp_valid_next            = 1'b1;
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && !rsp_ready;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cxe_pkg::ST_IDLE;
            stand_cnt_reg <= '0;
            chan_cnt_reg  <= '0;
            frame_cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stand_cnt_reg <= stand_cnt_next;
            chan_cnt_reg  <= chan_cnt_next;
            frame_cnt_reg <= frame_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // walk and result payload
    always_ff @(posedge clk)
    begin
        s1_reg        <= s1_next;
        s2_reg        <= s2_next;
        walk_addr_reg <= walk_addr_next;
        ov_reg        <= ov_next;
        done_reg      <= done_next;
        rsp_reg       <= rsp_next;
    end

    // shared complex multiply-accumulate with its buffers
    cxe_mac #(
        .MAX_STANDS   (MAX_STANDS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .wr_idx    (stand_cnt_reg),
        .sample_re (req.sample_re),
        .sample_im (req.sample_im),
        .s1        (s1_reg),
        .s2        (s2_reg),
        .addr      (mac_addr),
        .acc_re    (acc_re),
        .acc_im    (acc_im),
        .busy      (busy)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/cxe_port_check.sv
`default_nettype none

module cxe_port_check (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire cxe_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire cxe_pkg::rsp_t rsp
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // no new transfer in while a result waits undelivered
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("input taken while result stalled");

    // an integration-done result comes from a push and carries no visibility
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.integration_done |-> rsp.vis_re == '0 && rsp.vis_im == '0)
        else $error("done result with nonzero visibility");

    // a transfer in leaves the block unready or a result in flight next cycle
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready || rsp_valid)
        else $error("input transfer produced no activity");

endmodule

bind correlator_x_engine_baselines cxe_port_check u_port_check (.*);

`default_nettype wire
